// ===== hdl/modular_inverse_unit_defines.svh =====
// Assertion macros for the modular inverse unit.
// Each macro expects clk and arst_n in scope.
`ifndef MODULAR_INVERSE_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MIU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MIU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/miu_pkg.sv =====
package miu_pkg;

	localparam int FIELD_W   = 32;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 72;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_DBL,
		ST_STEP,
		ST_UPD1,
		ST_UPD2,
		ST_DONE
	} miu_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic iter_init;
		logic shift_up;
		logic dbl;
		logic step;
		logic upd1;
		logic upd2;
		logic out_load;
	} miu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic r1_zero;
		logic can_shift;
		logic last_bit;
	} miu_status_t;

endpackage

// ===== hdl/modular_inverse_unit.sv =====
// Modular inverse unit. Each request carries a value and a modulus and yields
// one result: the gcd of the two, a flag set when that gcd is 1, and the
// inverse of the value modulo the modulus in 0..modulus-1 (0 when no inverse
// exists, and 0 for a modulus of 1). A modulus of 0 returns the value as gcd,
// the flag set only for a value of 1, and inverse 0. Operands are the low
// DATA_WIDTH bits of the 32-bit fields.
// The extended Euclidean algorithm runs one quotient bit at a time on a
// single shift-subtract unit that also accumulates quotient times
// coefficient modulo the modulus. One request is in flight at a time.
// Each Euclid step aligns the divisor, then runs a per-bit double/add-mod loop.
// A finished result sits in the output register, so the next request is taken
// while it waits to be read.
`include "modular_inverse_unit_defines.svh"

module modular_inverse_unit
	import miu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] value, [63:32] modulus
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // [31:0] inverse, [32] inverse_exists,
	                                       // [64:33] common_divisor, [71:65] zero
);

	localparam int W = DATA_WIDTH;

	miu_cmd_t    cmd;
	miu_status_t status;

	logic [W+FIELD_W-1:0] value_ext, modulus_ext;
	logic [W+FIELD_W-1:0] inv_ext, gcd_ext;
	logic [W-1:0]         inverse, common_divisor;
	logic                 inverse_exists;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 out_busy;

	// Take the low DATA_WIDTH bits of each field, zero-extend if wider.
	assign value_ext   = {{W{1'b0}}, s_tdata[FIELD_W-1:0]};
	assign modulus_ext = {{W{1'b0}}, s_tdata[2*FIELD_W-1:FIELD_W]};

	// Output slot stays busy while a result waits and the sink stalls.
	assign out_busy = m_tvalid_q && !m_tready;

	miu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.out_busy  (out_busy),
		.status    (status),
		.cmd       (cmd)
	);

	miu_datapath #(
		.DATA_WIDTH (W)
	) u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.value          (value_ext[W-1:0]),
		.modulus        (modulus_ext[W-1:0]),
		.status         (status),
		.inverse        (inverse),
		.inverse_exists (inverse_exists),
		.common_divisor (common_divisor)
	);

	assign inv_ext = {{FIELD_W{1'b0}}, inverse};
	assign gcd_ext = {{FIELD_W{1'b0}}, common_divisor};

	// Output register: set on a finished result, drop once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {7'd0, gcd_ext[FIELD_W-1:0], inverse_exists, inv_ext[FIELD_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A request makes the block busy on the next cycle.
	`MIU_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after request")
	// The flag matches a gcd of one.
	`MIU_ASSERT_NOW(a_flag_gcd, m_tvalid, m_tdata[32] == (m_tdata[64:33] == 32'd1), "flag vs gcd")
	// No inverse reads as zero.
	`MIU_ASSERT_NOW(a_inv_zero, m_tvalid && !m_tdata[32], m_tdata[31:0] == 32'd0, "inverse not 0")
	// A new result never overwrites one that is still stalled.
	`MIU_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_tvalid_q || m_tready, "result overwritten")

endmodule

// ===== hdl/miu_ctrl.sv =====
module miu_ctrl
	import miu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        out_busy,
	input  miu_status_t status,
	output miu_cmd_t    cmd
);

	miu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.r1_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.iter_init = 1'b1;
					state_d       = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (status.can_shift) begin
					cmd.shift_up = 1'b1;
				end else begin
					state_d = ST_DBL;
				end
			end
			ST_DBL: begin
				cmd.dbl = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = status.last_bit ? ST_UPD1 : ST_DBL;
			end
			ST_UPD1: begin
				cmd.upd1 = 1'b1;
				state_d  = ST_UPD2;
			end
			ST_UPD2: begin
				cmd.upd2 = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/miu_datapath.sv =====
module miu_datapath
	import miu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  miu_cmd_t              cmd,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] modulus,
	output miu_status_t           status,
	output logic [DATA_WIDTH-1:0] inverse,
	output logic                  inverse_exists,
	output logic [DATA_WIDTH-1:0] common_divisor
);

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(W);

	logic [W-1:0]  m_q, r0_q, r1_q, s0_q, s1_q;
	logic [W-1:0]  rem_q, d_q, t_q, ms1_q;
	logic [KW-1:0] k_q;
	logic          borrow_q;

	logic [W:0]    t_dbl;
	logic [W-1:0]  t_dbl_mod;
	logic [W-1:0]  t_add_mod;
	logic [W:0]    s_diff;
	logic [W-1:0]  s_next;
	logic [W-1:0]  d_up;

	assign d_up      = {d_q[W-2:0], 1'b0};
	assign t_dbl     = {t_q, 1'b0};
	assign t_dbl_mod = (t_dbl >= {1'b0, m_q}) ? W'(t_dbl - {1'b0, m_q}) : t_dbl[W-1:0];
	// t + s1 wraps past m exactly when t >= m - s1
	assign t_add_mod = (t_q >= ms1_q) ? (t_q - ms1_q) : (t_q + s1_q);
	assign s_diff    = {1'b0, s0_q} - {1'b0, t_q};
	assign s_next    = borrow_q ? (t_q + m_q) : t_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q  <= modulus;
			r0_q <= value;
			r1_q <= modulus;
			s0_q <= W'(modulus > W'(1));
			s1_q <= '0;
		end
		if (cmd.iter_init) begin
			rem_q <= r0_q;
			d_q   <= r1_q;
			t_q   <= '0;
			ms1_q <= m_q - s1_q;
			k_q   <= '0;
		end
		if (cmd.shift_up) begin
			d_q <= d_up;
			k_q <= k_q + KW'(1);
		end
		if (cmd.dbl) begin
			t_q <= t_dbl_mod;
		end
		if (cmd.step) begin
			if (rem_q >= d_q) begin
				rem_q <= rem_q - d_q;
				t_q   <= t_add_mod;
			end
			d_q <= d_q >> 1;
			k_q <= k_q - KW'(1);
		end
		if (cmd.upd1) begin
			t_q      <= s_diff[W-1:0];
			borrow_q <= s_diff[W];
		end
		if (cmd.upd2) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
			s0_q <= s1_q;
			s1_q <= s_next;
		end
	end

	assign status.r1_zero   = (r1_q == '0);
	assign status.can_shift = !d_q[W-1] && (d_up <= rem_q);
	assign status.last_bit  = (k_q == '0);

	assign common_divisor = r0_q;
	assign inverse_exists = (r0_q == W'(1));
	assign inverse        = inverse_exists ? s0_q : '0;

endmodule
